// ----- rtl/core/ffha_pkg.sv -----
// Package for the first-fit heap allocator: sizes, status codes, command
// and status structs shared by controller and datapath. No dependencies.
`default_nettype none
package ffha_pkg;
  localparam int unsigned FreeEntries = 16;
  localparam int unsigned IdxW        = $clog2(FreeEntries);
  localparam logic [31:0] InitialSize = 32'd512;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StLimit = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef struct packed {
    logic            load;    // capture request
    logic            scan;    // examine entry at scan index
    logic            finish;  // apply update, produce result
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic early_done;         // allocate hit found
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/ffha_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
`default_nettype none
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] block_address;
  logic [31:0] block_size;
  modport source (output valid, kind, block_address, block_size, input ready);
  modport sink   (input valid, kind, block_address, block_size, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [1:0]  status;
  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ffha_datapath.sv -----
// Datapath: free table, heap top, request registers and scan logic.
// Depends on ffha_pkg.
`default_nettype none
module ffha_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ffha_pkg::dp_cmd_t cmd_i,
  output      ffha_pkg::dp_sts_t sts_o,
  input  wire logic             kind_i,
  input  wire logic [31:0]      block_address_i,
  input  wire logic [31:0]      block_size_i,
  input  wire logic             cfg_we_i,
  input  wire logic [31:0]      cfg_wdata_i,
  output      logic [31:0]      granted_address_o,
  output      logic [1:0]       status_o
);
  import ffha_pkg::*;

  logic [31:0] start_q [FreeEntries];
  logic [31:0] len_q   [FreeEntries];
  logic [FreeEntries-1:0] valid_q;
  logic [31:0] top_q, limit_q;
  logic        kind_q;
  logic [31:0] addr_q, size_q;
  logic [IdxW-1:0] idx_q;
  logic        hit_q, bef_q, aft_q, emp_q;
  logic [IdxW-1:0] hidx_q, bidx_q, aidx_q, eidx_q;
  logic [31:0] gaddr_q;
  logic [1:0]  st_q;

  logic [32:0] end_w, eend_w, ntop_w;
  logic        v_w, fit_w, bmatch_w, amatch_w;
  assign end_w    = {1'b0, addr_q} + {1'b0, size_q};
  assign eend_w   = {1'b0, start_q[idx_q]} + {1'b0, len_q[idx_q]};
  assign ntop_w   = {1'b0, top_q} + {1'b0, size_q};
  assign v_w      = valid_q[idx_q];
  assign fit_w    = v_w && (len_q[idx_q] >= size_q);
  assign bmatch_w = v_w && !bef_q && (eend_w == {1'b0, addr_q});
  assign amatch_w = v_w && !bmatch_w && !aft_q && ({1'b0, start_q[idx_q]} == end_w);

  assign sts_o.scan_last  = (idx_q == IdxW'(FreeEntries - 1));
  assign sts_o.early_done = (kind_q == KindAlloc) && fit_w;
  assign granted_address_o = gaddr_q;
  assign status_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= FreeEntries'(1);
      top_q   <= InitialSize;
      limit_q <= 32'hFFFF_FFFF;
      idx_q   <= '0;
      hit_q <= 1'b0; bef_q <= 1'b0; aft_q <= 1'b0; emp_q <= 1'b0;
      start_q[0] <= '0;
      len_q[0]   <= InitialSize;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        kind_q <= kind_i; addr_q <= block_address_i; size_q <= block_size_i;
        idx_q <= '0;
        hit_q <= 1'b0; bef_q <= 1'b0; aft_q <= 1'b0; emp_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (kind_q == KindAlloc) begin
          if (fit_w) begin
            hit_q <= 1'b1; hidx_q <= idx_q;
          end
        end else begin
          if (bmatch_w) begin bef_q <= 1'b1; bidx_q <= idx_q; end
          if (amatch_w) begin aft_q <= 1'b1; aidx_q <= idx_q; end
          if (!v_w && !emp_q) begin emp_q <= 1'b1; eidx_q <= idx_q; end
        end
        idx_q <= idx_q + 1'b1;
      end else if (cmd_i.finish) begin
        gaddr_q <= '0;
        st_q    <= StOk;
        if (kind_q == KindAlloc) begin
          if (hit_q) begin
            gaddr_q <= start_q[hidx_q];
            if (len_q[hidx_q] == size_q) valid_q[hidx_q] <= 1'b0;
            else begin
              start_q[hidx_q] <= start_q[hidx_q] + size_q;
              len_q[hidx_q]   <= len_q[hidx_q] - size_q;
            end
          end else if (ntop_w[32] || (ntop_w[31:0] > limit_q)) begin
            st_q <= StLimit;
          end else begin
            gaddr_q <= top_q;
            top_q   <= ntop_w[31:0];
          end
        end else if (size_q != '0 && !end_w[32]) begin
          if (bef_q) begin
            if (aft_q) begin
              len_q[bidx_q]   <= len_q[bidx_q] + size_q + len_q[aidx_q];
              valid_q[aidx_q] <= 1'b0;
            end else len_q[bidx_q] <= len_q[bidx_q] + size_q;
          end else if (aft_q) begin
            start_q[aidx_q] <= addr_q;
            len_q[aidx_q]   <= len_q[aidx_q] + size_q;
          end else if (emp_q) begin
            start_q[eidx_q] <= addr_q;
            len_q[eidx_q]   <= size_q;
            valid_q[eidx_q] <= 1'b1;
          end else st_q <= StFull;
        end
      end
    end
  end

  a_limit_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.finish) && st_q == StLimit |-> gaddr_q == '0)
    else $error("limit error with nonzero address");
  a_top_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we_i) && !$past(cmd_i.finish) |-> $stable(top_q))
    else $error("heap top moved outside finish");
  a_idx_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> idx_q == '0)
    else $error("scan index not cleared");
endmodule
`default_nettype wire

// ----- rtl/core/ffha_ctrl.sv -----
// Controller state machine: sequences load, table scan, update and result.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire ffha_pkg::dp_sts_t sts_i,
  output      ffha_pkg::dp_cmd_t cmd_o
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_FIN = 4'b0100, S_OUT = 4'b1000
  } state_e;
  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin cmd_o.load = 1'b1; state_d = S_SCAN; end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last || sts_i.early_done) state_d = S_FIN;
      end
      S_FIN: begin cmd_o.finish = 1'b1; state_d = S_OUT; end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({cmd_o.load, cmd_o.scan, cmd_o.finish}) || cmd_o == '0)
    else $error("overlapping commands");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o)
    else $error("result not presented after finish");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
endmodule
`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator.sv -----
// First-fit heap allocator: one request in, one result out.
// Each item passes through these steps: take the request, scan the
// free-table entries (16 entries, one per cycle; an allocate stops at the
// first fit, a deallocate scans all 16), update the table and present the
// result. No new request is taken until the result has been transferred,
// so output stalls hold back the next request. Depends on ffha_pkg,
// ffha_if, ffha_ctrl, ffha_datapath.
`default_nettype none
module first_fit_heap_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ffha_req_if.sink         req,
  ffha_rsp_if.source       rsp,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import ffha_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  ffha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .kind_i(req.kind), .block_address_i(req.block_address),
    .block_size_i(req.block_size),
    .cfg_we_i, .cfg_wdata_i,
    .granted_address_o(rsp.granted_address), .status_o(rsp.status)
  );
endmodule
`default_nettype wire

// ----- tb/ffha_test_if.sv -----
// Testbench-side package: defines the grant_t record of an expected result.
// Depends on ffha_pkg; the channel interfaces come from rtl/core/ffha_if.sv.
package ffha_test_pkg;
  import ffha_pkg::*;
  typedef struct {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } grant_t;
endpackage

// ----- tb/first_fit_heap_allocator_test.sv -----
// Testbench for first_fit_heap_allocator: drives alloc/free requests with random
// gaps, predicts each result from an internal free-table model and checks it.
// Depends on ffha_pkg, ffha_if, ffha_test_pkg and the RTL.
module first_fit_heap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;
  import ffha_test_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] slot_start [FreeEntries];
  logic [31:0] slot_len [FreeEntries];
  logic        slot_used [FreeEntries];
  logic [31:0] top_mdl;
  logic [31:0] limit_mdl;
  grant_t      pending_grants [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          rsp_wait = 0;

  initial begin
    req.valid = 1'b0;
    req.kind = KindAlloc;
    req.block_address = '0;
    req.block_size = '0;
    rsp.ready = 1'b0;
  end

  function automatic grant_t predict_alloc(logic [31:0] size);
    grant_t g;
    logic [32:0] nt;
    g.granted_address = '0;
    g.status = StOk;
    for (int i = 0; i < FreeEntries; i++) begin
      if (slot_used[i] && slot_len[i] >= size) begin
        g.granted_address = slot_start[i];
        if (slot_len[i] == size) begin
          slot_used[i] = 1'b0;
        end else begin
          slot_start[i] = slot_start[i] + size;
          slot_len[i] = slot_len[i] - size;
        end
        return g;
      end
    end
    nt = {1'b0, top_mdl} + {1'b0, size};
    if (nt > {1'b0, limit_mdl} || nt[32]) begin
      g.status = StLimit;
      return g;
    end
    g.granted_address = top_mdl;
    top_mdl = nt[31:0];
    return g;
  endfunction

  function automatic grant_t predict_free(logic [31:0] addr, logic [31:0] size);
    grant_t g;
    logic [32:0] fin, e, len;
    int lo, hi, hole;
    g.granted_address = '0;
    g.status = StOk;
    lo = -1; hi = -1; hole = -1;
    fin = {1'b0, addr} + {1'b0, size};
    if (size == 0 || fin[32]) return g;
    for (int i = 0; i < FreeEntries; i++) begin
      if (slot_used[i]) begin
        e = {1'b0, slot_start[i]} + {1'b0, slot_len[i]};
        if (lo < 0 && e == {1'b0, addr}) lo = i;
        else if (hi < 0 && {1'b0, slot_start[i]} == fin) hi = i;
      end else if (hole < 0) begin
        hole = i;
      end
    end
    if (lo >= 0) begin
      len = {1'b0, slot_len[lo]} + {1'b0, size};
      if (hi >= 0) begin
        len = len + {1'b0, slot_len[hi]};
        slot_used[hi] = 1'b0;
      end
      slot_len[lo] = len[31:0];
    end else if (hi >= 0) begin
      slot_start[hi] = addr;
      slot_len[hi] = slot_len[hi] + size;
    end else if (hole >= 0) begin
      slot_start[hole] = addr;
      slot_len[hole] = size;
      slot_used[hole] = 1'b1;
    end else begin
      g.status = StFull;
    end
    return g;
  endfunction

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(logic kind, logic [31:0] addr, logic [31:0] size);
    grant_t g;
    int gap;
    gap = short_or_long_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.kind <= kind;
    req.block_address <= addr;
    req.block_size <= size;
    do @(posedge clk_i); while (!req.ready);
    if (kind == KindAlloc) g = predict_alloc(size);
    else g = predict_free(addr, size);
    pending_grants.push_back(g);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_mdl = value;
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    grant_t g;
    if (rsp.valid && rsp.ready) begin
      if (pending_grants.size() == 0) begin
        $error("result with no request outstanding: addr %h status %0d",
               rsp.granted_address, rsp.status);
        fail_count++;
      end else begin
        g = pending_grants.pop_front();
        if (rsp.granted_address !== g.granted_address) begin
          $error("granted_address expected %h actual %h", g.granted_address,
                 rsp.granted_address);
          fail_count++;
        end
        if (rsp.status !== g.status) begin
          $error("status expected %0d actual %0d", g.status, rsp.status);
          fail_count++;
        end
      end
    end
    if (rsp_wait > 0) begin
      rsp.ready <= 1'b0;
      rsp_wait--;
    end else begin
      rsp.ready <= 1'b1;
      rsp_wait = short_or_long_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL first_fit_heap_allocator");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(KindAlloc, 32'h0, 32'd0);
    send_request(KindAlloc, 32'hFFFF_FFFF, 32'd100);
    send_request(KindAlloc, 32'h0, 32'd412);
    send_request(KindAlloc, 32'h0, 32'd0);
    send_request(KindAlloc, 32'h0, 32'd64);
    send_request(KindFree, 32'd0, 32'd100);
    send_request(KindFree, 32'd200, 32'd100);
    send_request(KindFree, 32'd100, 32'd100);
    send_request(KindFree, 32'd5000, 32'd0);
    send_request(KindFree, 32'hFFFF_FF00, 32'h0000_0200);
    send_request(KindFree, 32'h0, 32'hFFFF_FFFF);
    for (int i = 0; i < 17; i++) send_request(KindFree, 32'h1000 + i * 32'h20, 32'h10);
    send_request(KindAlloc, 32'h0, 32'hFFFF_FFFF);
  endtask

  task automatic test_limits();
    write_limit(32'd0);
    send_request(KindAlloc, 32'h0, 32'h7000_0000);
    write_limit(32'h0000_4000);
    send_request(KindAlloc, 32'h0, 32'h100);
    send_request(KindAlloc, 32'h0, 32'h4000);
    write_limit(32'hFFFF_FFFF);
  endtask

  task automatic test_random(int count);
    logic [31:0] held_addr [$];
    logic [31:0] held_size [$];
    logic [31:0] a, s;
    grant_t g;
    int k;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        // hold until every result is back, then change the limit
        drain();
        write_limit($urandom_range(0, 3) == 0 ? $urandom() : 32'hFFFF_FFFF);
      end
      k = $urandom_range(0, 9);
      if (k < 5) begin
        s = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 256);
        send_request(KindAlloc, $urandom(), s);
        g = pending_grants[$];
        if (g.status == StOk && s != 0 && pending_grants.size() > 0) begin
          held_addr.push_back(g.granted_address);
          held_size.push_back(s);
        end
      end else if (k < 9 && held_addr.size() > 0) begin
        int j;
        j = $urandom_range(0, held_addr.size() - 1);
        a = held_addr[j];
        s = held_size[j];
        held_addr.delete(j);
        held_size.delete(j);
        send_request(KindFree, a, s);
      end else begin
        send_request(KindFree, $urandom(), $urandom() >> $urandom_range(0, 31));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < FreeEntries; i++) begin
      slot_start[i] = '0;
      slot_len[i] = '0;
      slot_used[i] = 1'b0;
    end
    slot_len[0] = InitialSize;
    slot_used[0] = 1'b1;
    top_mdl = InitialSize;
    limit_mdl = 32'hFFFF_FFFF;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_random(1500);
    drain();
    if (fail_count == 0) begin
      $display("PASS first_fit_heap_allocator");
    end else begin
      $display("FAIL first_fit_heap_allocator");
    end
    $finish;
  end
endmodule
